// ===== rtl/bandit_arm_scheduler_unit_macros.svh =====
// Assertion macros shared by the bandit arm scheduler RTL.
`ifndef BANDIT_ARM_SCHEDULER_UNIT_MACROS_SVH
`define BANDIT_ARM_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BAS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bas: implication check failed");

// Next-cycle implication, disabled during reset.
`define BAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bas: next-cycle check failed");

`endif

// ===== rtl/bas_pkg.sv =====
// Types, codes and helpers for the bandit arm scheduler.
package bas_pkg;

  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_CHOOSE = 2'd1;
  localparam logic [1:0] OP_RAISE  = 2'd2;
  localparam logic [1:0] OP_LOWER  = 2'd3;

  localparam logic [2:0] CFG_WINDOW_MODE   = 3'd0;
  localparam logic [2:0] CFG_BUCKET_LENGTH = 3'd1;
  localparam logic [2:0] CFG_MIN_RUN_TIME  = 3'd2;
  localparam logic [2:0] CFG_GAMMA         = 3'd3;
  localparam logic [2:0] CFG_ARMS_IN_USE   = 3'd4;
  localparam logic [2:0] CFG_EPSILON_MIN   = 3'd5;
  localparam logic [2:0] CFG_EPSILON_MAX   = 3'd6;
  localparam logic [2:0] CFG_EPSILON_STEP  = 3'd7;

  localparam logic        RST_WINDOW_MODE   = 1'b1;
  localparam logic [31:0] RST_BUCKET_LENGTH = 32'd60000;
  localparam logic [31:0] RST_MIN_RUN_TIME  = 32'd10000;
  localparam logic [15:0] RST_GAMMA         = 16'd65208;
  localparam logic [4:0]  RST_ARMS_IN_USE   = 5'd16;
  localparam logic [15:0] RST_EPSILON_MIN   = 16'd655;
  localparam logic [15:0] RST_EPSILON_MAX   = 16'd49152;
  localparam logic [15:0] RST_EPSILON_STEP  = 16'd3277;
  localparam logic [15:0] RST_EPSILON       = 16'd655;

  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  // Serial arithmetic unit widths.
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = PROD_W;
  localparam int DIV_D_W = 48;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  arm;
    logic [23:0] coverage;
    logic [31:0] elapsed;
    logic [15:0] random_draw;
    logic [3:0]  random_arm;
  } item_t;

  typedef struct packed {
    logic [3:0]  selected_arm;
    logic        explored;
    logic [31:0] best_score;
    logic [15:0] epsilon_now;
  } result_t;

  // One arm's stored state, one RAM word.
  typedef struct packed {
    logic [47:0] window_coverage;
    logic [47:0] window_time;
    logic [47:0] total_coverage;
    logic [47:0] total_time;
    logic [31:0] bucket_fill;
  } arm_state_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX32 : s[31:0];
  endfunction

endpackage

// ===== rtl/bandit_arm_scheduler_unit.sv =====
// Bandit arm scheduler: epsilon-greedy arm selection over a per-arm RAM.
// A raise or lower steps epsilon; a record with static scoring updates the
// arm's totals; a dynamic record also closes each full bucket in turn (a
// serial multiply, a serial divide and two discount multiplies), up to
// MAX_CLOSINGS buckets; a choose scores each arm in use, with a serial
// divide unless the arm scores maximum at once, and on exploring reduces
// random_arm modulo the arm count. Arm state lives in one RAM with one
// valid flip-flop per arm, so no clearing pass follows reset. The item
// side stalls while an item is in work; a finished result waits in the
// output register while the next item is accepted.
`include "bandit_arm_scheduler_unit_macros.svh"

module bandit_arm_scheduler_unit #(
  parameter int NUM_ARMS     = 16,
  parameter int MAX_CLOSINGS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bas_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output bas_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  localparam int AW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
  localparam int NW = $clog2(NUM_ARMS + 1);
  localparam int CW = $clog2(MAX_CLOSINGS + 1);
  localparam int SW = $bits(bas_pkg::arm_state_t);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_LOAD, S_CHECK, S_MUL, S_DIV, S_DSCS, S_DSCW, S_DSTW,
    S_WRITE, S_SRD, S_SSC, S_SDIV, S_SCMP, S_SEL, S_MOD, S_EPS, S_DONE
  } state_t;

  // configuration registers
  logic        window_mode;
  logic [31:0] bucket_length;
  logic [31:0] min_run_time;
  logic [15:0] gamma;
  logic [4:0]  arms_in_use;
  logic [15:0] epsilon_min;
  logic [15:0] epsilon_max;
  logic [15:0] epsilon_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode   <= bas_pkg::RST_WINDOW_MODE;
      bucket_length <= bas_pkg::RST_BUCKET_LENGTH;
      min_run_time  <= bas_pkg::RST_MIN_RUN_TIME;
      gamma         <= bas_pkg::RST_GAMMA;
      arms_in_use   <= bas_pkg::RST_ARMS_IN_USE;
      epsilon_min   <= bas_pkg::RST_EPSILON_MIN;
      epsilon_max   <= bas_pkg::RST_EPSILON_MAX;
      epsilon_step  <= bas_pkg::RST_EPSILON_STEP;
    end else if (cfg_write) begin
      case (cfg_index)
        bas_pkg::CFG_WINDOW_MODE:   window_mode   <= cfg_data[0];
        bas_pkg::CFG_BUCKET_LENGTH: bucket_length <= cfg_data;
        bas_pkg::CFG_MIN_RUN_TIME:  min_run_time  <= cfg_data;
        bas_pkg::CFG_GAMMA:         gamma         <= cfg_data[15:0];
        bas_pkg::CFG_ARMS_IN_USE:   arms_in_use   <= cfg_data[4:0];
        bas_pkg::CFG_EPSILON_MIN:   epsilon_min   <= cfg_data[15:0];
        bas_pkg::CFG_EPSILON_MAX:   epsilon_max   <= cfg_data[15:0];
        bas_pkg::CFG_EPSILON_STEP:  epsilon_step  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  state_t               state;
  bas_pkg::item_t       cur;
  logic [15:0]          epsilon;
  logic [NUM_ARMS-1:0]  arm_valid;
  logic                 rd_ok;
  logic [AW-1:0]        rd_addr;
  logic [SW-1:0]        rd_data;
  bas_pkg::arm_state_t  ent;
  logic                 wr_en;

  // working copy of one arm
  logic [47:0]   wc, wt, tc, tt;
  logic [31:0]   fl;
  logic [39:0]   rc;
  logic [31:0]   rt;
  logic [31:0]   part_r;
  logic [CW-1:0] clos;

  // choose bookkeeping
  logic [AW-1:0] idx;
  logic [AW-1:0] bi;
  logic [NW-1:0] n_r;
  logic [31:0]   bs;
  logic [31:0]   score_r;
  logic [8:0]    mod_r;

  // result registers
  logic [3:0]    sel_r;
  logic          expl_r;
  logic [31:0]   best_r;

  // shared arithmetic units
  logic                          mul_start, mul_busy, mul_done;
  logic [bas_pkg::MUL_A_W-1:0]   mul_a;
  logic [bas_pkg::MUL_B_W-1:0]   mul_b;
  logic [bas_pkg::PROD_W-1:0]    mul_prod;
  logic                          div_start, div_busy, div_done;
  logic [bas_pkg::DIV_N_W-1:0]   div_dvd;
  logic [bas_pkg::DIV_D_W-1:0]   div_dsr;
  logic [bas_pkg::DIV_N_W-1:0]   div_q;

  bas_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .busy(mul_busy), .done(mul_done), .prod(mul_prod)
  );

  bas_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  bas_ram #(.WIDTH(SW), .DEPTH(NUM_ARMS)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(AW'(cur.arm)),
    .wr_data({wc, wt, tc, tt, fl}), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign wr_en      = (state == S_WRITE);
  assign item_stall = (state != S_IDLE);

  // combinational helpers
  logic          fits;
  logic [31:0]   part;
  logic [47:0]   num, den;
  logic [8:0]    arms_ext;
  logic [NW-1:0] n_clamp;
  logic          arm_ok;
  logic signed [17:0] e_sum, e_lo, e_hi;

  always_comb begin
    ent      = rd_ok ? bas_pkg::arm_state_t'(rd_data) : '0;
    fits     = (rt == '0) || ((fl <= bucket_length) && (rt <= bucket_length - fl));
    part     = (fl < bucket_length) ? bucket_length - fl : '0;
    num      = window_mode ? ent.window_coverage : ent.total_coverage;
    den      = window_mode ? ent.window_time : ent.total_time;
    arms_ext = 9'(arms_in_use);
    if (arms_ext == '0) begin
      n_clamp = NW'(1);
    end else if (arms_ext > 9'(NUM_ARMS)) begin
      n_clamp = NW'(NUM_ARMS);
    end else begin
      n_clamp = NW'(arms_ext);
    end
    arm_ok = (9'(item.arm) < 9'(NUM_ARMS));
    // epsilon step, raised to min first, then lowered to max
    if (cur.operation == bas_pkg::OP_RAISE) begin
      e_sum = $signed({2'b00, epsilon}) + $signed({2'b00, epsilon_step});
    end else begin
      e_sum = $signed({2'b00, epsilon}) - $signed({2'b00, epsilon_step});
    end
    e_lo = (e_sum < $signed({2'b00, epsilon_min})) ? $signed({2'b00, epsilon_min}) : e_sum;
    e_hi = (e_lo > $signed({2'b00, epsilon_max})) ? $signed({2'b00, epsilon_max}) : e_lo;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      epsilon      <= bas_pkg::RST_EPSILON;
      arm_valid    <= '0;
      result_valid <= 1'b0;
      mul_start    <= 1'b0;
      div_start    <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      rd_ok     <= arm_valid[rd_addr];
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur    <= item;
            sel_r  <= '0;
            expl_r <= 1'b0;
            best_r <= '0;
            case (item.operation)
              bas_pkg::OP_RECORD: begin
                rd_addr <= AW'(item.arm);
                state   <= arm_ok ? S_RD : S_DONE;
              end
              bas_pkg::OP_CHOOSE: begin
                idx     <= '0;
                rd_addr <= '0;
                n_r     <= n_clamp;
                bs      <= '0;
                bi      <= '0;
                state   <= S_SRD;
              end
              default: state <= S_EPS;
            endcase
          end
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          wc    <= ent.window_coverage;
          wt    <= ent.window_time;
          tc    <= bas_pkg::sat_add48(ent.total_coverage, 48'(cur.coverage));
          tt    <= bas_pkg::sat_add48(ent.total_time, 48'(cur.elapsed));
          fl    <= ent.bucket_fill;
          rc    <= {cur.coverage, 16'h0000};
          rt    <= cur.elapsed;
          clos  <= '0;
          state <= window_mode ? S_CHECK : S_WRITE;
        end
        S_CHECK: begin
          if (fits || (clos == CW'(MAX_CLOSINGS))) begin
            // remainder into the open bucket
            wc    <= bas_pkg::sat_add48(wc, 48'(rc));
            wt    <= bas_pkg::sat_add48(wt, {rt, 16'h0000});
            fl    <= bas_pkg::sat_add32(fl, rt);
            state <= S_WRITE;
          end else begin
            part_r    <= part;
            mul_a     <= bas_pkg::MUL_A_W'(rc);
            mul_b     <= part;
            mul_start <= 1'b1;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            div_dvd   <= mul_prod;
            div_dsr   <= bas_pkg::DIV_D_W'(rt);
            div_start <= 1'b1;
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            // close the bucket with its share of coverage
            wc    <= bas_pkg::sat_add48(wc, 48'(div_q[39:0]));
            wt    <= bas_pkg::sat_add48(wt, {part_r, 16'h0000});
            rc    <= rc - div_q[39:0];
            rt    <= rt - part_r;
            fl    <= '0;
            clos  <= clos + CW'(1);
            state <= S_DSCS;
          end
        end
        S_DSCS: begin
          mul_a     <= wc;
          mul_b     <= 32'(gamma);
          mul_start <= 1'b1;
          state     <= S_DSCW;
        end
        S_DSCW: begin
          if (mul_done) begin
            wc        <= mul_prod[63:16];
            mul_a     <= wt;
            mul_b     <= 32'(gamma);
            mul_start <= 1'b1;
            state     <= S_DSTW;
          end
        end
        S_DSTW: begin
          if (mul_done) begin
            wt    <= mul_prod[63:16];
            state <= S_CHECK;
          end
        end
        S_WRITE: begin
          arm_valid[AW'(cur.arm)] <= 1'b1;
          state <= S_DONE;
        end
        S_SRD: state <= S_SSC;
        S_SSC: begin
          if (ent.total_time < 48'(min_run_time) || den == '0) begin
            score_r <= bas_pkg::MAX32;
            state   <= S_SCMP;
          end else begin
            div_dvd   <= {16'h0000, num, 16'h0000};
            div_dsr   <= den;
            div_start <= 1'b1;
            state     <= S_SDIV;
          end
        end
        S_SDIV: begin
          if (div_done) begin
            score_r <= (|div_q[79:32]) ? bas_pkg::MAX32 : div_q[31:0];
            state   <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (idx == '0 || score_r > bs) begin
            bs <= score_r;
            bi <= idx;
          end
          if (NW'(idx) + NW'(1) == n_r) begin
            state <= S_SEL;
          end else begin
            idx     <= idx + AW'(1);
            rd_addr <= idx + AW'(1);
            state   <= S_SRD;
          end
        end
        S_SEL: begin
          best_r <= bs;
          sel_r  <= 4'(bi);
          if (cur.random_draw < epsilon) begin
            expl_r <= 1'b1;
            mod_r  <= 9'(cur.random_arm);
            state  <= S_MOD;
          end else begin
            state <= S_DONE;
          end
        end
        S_MOD: begin
          // random_arm modulo the arm count by repeated subtraction
          if (mod_r >= 9'(n_r)) begin
            mod_r <= mod_r - 9'(n_r);
          end else begin
            sel_r <= 4'(mod_r);
            state <= S_DONE;
          end
        end
        S_EPS: begin
          epsilon <= e_hi[15:0];
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid        <= 1'b1;
            result.selected_arm <= sel_r;
            result.explored     <= expl_r;
            result.best_score   <= best_r;
            result.epsilon_now  <= epsilon;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `BAS_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)
  `BAS_ASSERT_IMPLY(a_units_idle, state == S_IDLE, !mul_busy && !div_busy)
  `BAS_ASSERT_IMPLY(a_closing_limit, 1'b1, clos <= CW'(MAX_CLOSINGS) || state != S_CHECK)

endmodule

// ===== rtl/bas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/bas_mul.sv =====
// Shift-add serial multiplier, one multiplier bit per cycle.
module bas_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bas_pkg::MUL_A_W-1:0] a,
  input  logic [bas_pkg::MUL_B_W-1:0] b,
  output logic                       busy,
  output logic                       done,
  output logic [bas_pkg::PROD_W-1:0]  prod
);

  localparam int CNT_W = $clog2(bas_pkg::MUL_B_W);

  logic [bas_pkg::PROD_W-1:0]  a_sh;
  logic [bas_pkg::MUL_B_W-1:0] b_sh;
  logic [CNT_W-1:0]            cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_sh <= bas_pkg::PROD_W'(a);
        b_sh <= b;
        prod <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        // accumulate one partial product
        prod <= prod + (b_sh[0] ? a_sh : '0);
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(bas_pkg::MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/bas_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module bas_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bas_pkg::DIV_N_W-1:0]  dividend,
  input  logic [bas_pkg::DIV_D_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [bas_pkg::DIV_N_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(bas_pkg::DIV_N_W);

  logic [bas_pkg::DIV_D_W-1:0] rem;
  logic [bas_pkg::DIV_D_W-1:0] dsr;
  logic [CNT_W-1:0]            cnt;
  logic [bas_pkg::DIV_D_W:0]   sh;
  logic                        qbit;

  // trial subtract of the shifted remainder
  always_comb begin
    sh   = {rem, quotient[bas_pkg::DIV_N_W-1]};
    qbit = (sh >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        rem      <= qbit ? bas_pkg::DIV_D_W'(sh - {1'b0, dsr}) : sh[bas_pkg::DIV_D_W-1:0];
        quotient <= {quotient[bas_pkg::DIV_N_W-2:0], qbit};
        cnt      <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(bas_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the bandit arm scheduler unit.
`timescale 1ns / 1ps

module tb;

  localparam int  ARM_COUNT   = 16;
  localparam int  CLOSE_LIMIT = 64;
  localparam longint CYCLE_LIMIT = 60000000;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  bas_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  bas_pkg::result_t result;
  logic             cfg_write;
  logic [2:0]       cfg_index;
  logic [31:0]      cfg_data;

  bandit_arm_scheduler_unit #(.NUM_ARMS(ARM_COUNT), .MAX_CLOSINGS(CLOSE_LIMIT)) uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow configuration
  logic        sh_dynamic;
  logic [31:0] sh_bucket_len;
  logic [31:0] sh_min_run;
  logic [15:0] sh_gamma;
  logic [4:0]  sh_arms;
  logic [15:0] sh_eps_min;
  logic [15:0] sh_eps_max;
  logic [15:0] sh_eps_step;

  // Shadow arm table
  logic [47:0] arm_win_cov  [ARM_COUNT];
  logic [47:0] arm_win_time [ARM_COUNT];
  logic [47:0] arm_tot_cov  [ARM_COUNT];
  logic [47:0] arm_tot_time [ARM_COUNT];
  logic [31:0] arm_fill     [ARM_COUNT];
  logic [15:0] eps_q;

  bas_pkg::result_t pending_results[$];
  int      fails;
  longint  cycles;
  int      tx_idle_pct;
  int      rx_idle_pct;
  int      hold_left;
  bit      hold_req;

  function automatic logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
    logic [63:0] s;
    s = {16'b0, a} + {16'b0, b};
    return (s > {16'b0, bas_pkg::MAX48}) ? bas_pkg::MAX48 : s[47:0];
  endfunction

  function automatic logic [47:0] scale_gamma(logic [47:0] x);
    logic [63:0] p;
    p = {16'b0, x} * {48'b0, sh_gamma};
    return p[63:16];
  endfunction

  function automatic logic [31:0] score_q16(logic [47:0] num, logic [47:0] den);
    logic [63:0] q, r;
    if (den == 0) return bas_pkg::MAX32;
    q = {16'b0, num} / {16'b0, den};
    if (q >= 64'd65536) return bas_pkg::MAX32;
    r = {16'b0, num} % {16'b0, den};
    return {q[15:0], 16'b0} | 32'((r << 16) / {16'b0, den});
  endfunction

  // Split a run over buckets, discounting the window at each closing
  function automatic void record_run_model(int a, logic [23:0] cov, logic [31:0] t);
    logic [63:0]  rc, rt, len, fill, part, share, nf;
    logic [127:0] prod;
    int           closings;
    bit           fits;
    rc  = {24'b0, cov, 16'b0};
    rt  = {32'b0, t};
    len = {32'b0, sh_bucket_len};
    arm_tot_cov[a]  = add_sat48(arm_tot_cov[a], {24'b0, cov});
    arm_tot_time[a] = add_sat48(arm_tot_time[a], {16'b0, t});
    if (!sh_dynamic) return;
    closings = 0;
    while (1) begin
      fill = {32'b0, arm_fill[a]};
      fits = (rt == 0) || (fill <= len && rt <= len - fill);
      if (fits || closings >= CLOSE_LIMIT) begin
        nf = fill + rt;
        arm_win_cov[a]  = add_sat48(arm_win_cov[a], rc[47:0]);
        arm_win_time[a] = add_sat48(arm_win_time[a], rt[47:0] << 16);
        arm_fill[a]     = (nf > 64'hFFFF_FFFF) ? bas_pkg::MAX32 : nf[31:0];
        return;
      end
      part  = (fill < len) ? len - fill : 64'd0;
      prod  = 128'(rc) * 128'(part);
      share = 64'(prod / 128'(rt));
      arm_win_cov[a]  = scale_gamma(add_sat48(arm_win_cov[a], share[47:0]));
      arm_win_time[a] = scale_gamma(add_sat48(arm_win_time[a], part[47:0] << 16));
      arm_fill[a]     = 32'd0;
      rc = rc - share;
      rt = rt - part;
      closings++;
    end
  endfunction

  // Expected result of one item; updates the shadow state
  function automatic bas_pkg::result_t predict_result(bas_pkg::item_t it);
    bas_pkg::result_t r;
    int               n, bi;
    logic [31:0]      s, bs;
    longint           e;
    r = '0;
    case (it.operation)
      bas_pkg::OP_RECORD: record_run_model(int'(it.arm), it.coverage, it.elapsed);
      bas_pkg::OP_CHOOSE: begin
        n = int'(sh_arms);
        if (n < 1) n = 1;
        if (n > ARM_COUNT) n = ARM_COUNT;
        bs = '0;
        bi = 0;
        for (int i = 0; i < n; i++) begin
          if (arm_tot_time[i] < {16'b0, sh_min_run}) s = bas_pkg::MAX32;
          else if (sh_dynamic) s = score_q16(arm_win_cov[i], arm_win_time[i]);
          else s = score_q16(arm_tot_cov[i], arm_tot_time[i]);
          if (i == 0 || s > bs) begin
            bs = s;
            bi = i;
          end
        end
        r.best_score   = bs;
        r.selected_arm = 4'(bi);
        if (it.random_draw < eps_q) begin
          r.selected_arm = 4'(int'(it.random_arm) % n);
          r.explored     = 1'b1;
        end
      end
      default: begin
        e = longint'(eps_q);
        e = (it.operation == bas_pkg::OP_RAISE) ? e + longint'(sh_eps_step)
                                                : e - longint'(sh_eps_step);
        if (e < longint'(sh_eps_min)) e = longint'(sh_eps_min);
        if (e > longint'(sh_eps_max)) e = longint'(sh_eps_max);
        eps_q = 16'(e);
      end
    endcase
    r.epsilon_now = eps_q;
    return r;
  endfunction

  function automatic bas_pkg::item_t make_item(logic [1:0] op, logic [3:0] a,
                                               logic [23:0] cov, logic [31:0] el,
                                               logic [15:0] draw, logic [3:0] ra);
    bas_pkg::item_t it;
    it.operation   = op;
    it.arm         = a;
    it.coverage    = cov;
    it.elapsed     = el;
    it.random_draw = draw;
    it.random_arm  = ra;
    return it;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stall, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      hold_left    = 400;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    bas_pkg::result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        fails++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.selected_arm !== exp_r.selected_arm) begin
          $display("%0t: selected_arm exp %0d got %0d", $time, exp_r.selected_arm,
                   result.selected_arm);
          fails++;
        end
        if (result.explored !== exp_r.explored) begin
          $display("%0t: explored exp %0d got %0d", $time, exp_r.explored, result.explored);
          fails++;
        end
        if (result.best_score !== exp_r.best_score) begin
          $display("%0t: best_score exp %h got %h", $time, exp_r.best_score,
                   result.best_score);
          fails++;
        end
        if (result.epsilon_now !== exp_r.epsilon_now) begin
          $display("%0t: epsilon_now exp %0d got %0d", $time, exp_r.epsilon_now,
                   result.epsilon_now);
          fails++;
        end
      end
    end
  end

  // One item transfer, with an optional random gap before it
  task automatic send_item(input bas_pkg::item_t it);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results = {pending_results, predict_result(it)};
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      bas_pkg::CFG_WINDOW_MODE:   sh_dynamic    = val[0];
      bas_pkg::CFG_BUCKET_LENGTH: sh_bucket_len = val;
      bas_pkg::CFG_MIN_RUN_TIME:  sh_min_run    = val;
      bas_pkg::CFG_GAMMA:         sh_gamma      = val[15:0];
      bas_pkg::CFG_ARMS_IN_USE:   sh_arms       = val[4:0];
      bas_pkg::CFG_EPSILON_MIN:   sh_eps_min    = val[15:0];
      bas_pkg::CFG_EPSILON_MAX:   sh_eps_max    = val[15:0];
      bas_pkg::CFG_EPSILON_STEP:  sh_eps_step   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic restore_defaults;
    set_reg(bas_pkg::CFG_WINDOW_MODE, 32'(bas_pkg::RST_WINDOW_MODE));
    set_reg(bas_pkg::CFG_BUCKET_LENGTH, bas_pkg::RST_BUCKET_LENGTH);
    set_reg(bas_pkg::CFG_MIN_RUN_TIME, bas_pkg::RST_MIN_RUN_TIME);
    set_reg(bas_pkg::CFG_GAMMA, 32'(bas_pkg::RST_GAMMA));
    set_reg(bas_pkg::CFG_ARMS_IN_USE, 32'(bas_pkg::RST_ARMS_IN_USE));
    set_reg(bas_pkg::CFG_EPSILON_MIN, 32'(bas_pkg::RST_EPSILON_MIN));
    set_reg(bas_pkg::CFG_EPSILON_MAX, 32'(bas_pkg::RST_EPSILON_MAX));
    set_reg(bas_pkg::CFG_EPSILON_STEP, 32'(bas_pkg::RST_EPSILON_STEP));
  endtask

  // Reset values, every operation, scoring, bucket closing, arm count and epsilon corner cases
  task automatic test_directed_cases;
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'hFFFF, 4'd0));
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'd0, 4'd15));
    send_item(make_item(bas_pkg::OP_RECORD, 4'd3, 24'd1000, 32'd0, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_RECORD, 4'd3, 24'hFFFFFF, 32'd150000, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_RECORD, 4'd5, 24'd0, 32'd30000, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_RECORD, 4'd15, 24'd4000, 32'd20000, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'hFFFF, 4'd0));
    send_item(make_item(bas_pkg::OP_RAISE, 4'd0, 24'd0, 32'd0, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_LOWER, 4'd0, 24'd0, 32'd0, 16'd0, 4'd0));
    // arms never run have zero window time
    set_reg(bas_pkg::CFG_MIN_RUN_TIME, 32'd0);
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'hFFFF, 4'd0));
    // bucket shorter than the fill: closes at once
    set_reg(bas_pkg::CFG_BUCKET_LENGTH, 32'd1000);
    send_item(make_item(bas_pkg::OP_RECORD, 4'd3, 24'd500, 32'd10, 16'd0, 4'd0));
    // lifetime scoring
    set_reg(bas_pkg::CFG_WINDOW_MODE, 32'd0);
    send_item(make_item(bas_pkg::OP_RECORD, 4'd7, 24'd12345, 32'd999, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'hFFFF, 4'd0));
    set_reg(bas_pkg::CFG_WINDOW_MODE, 32'd1);
    // zero bucket length: closing limit, then window and fill saturate
    set_reg(bas_pkg::CFG_BUCKET_LENGTH, 32'd0);
    set_reg(bas_pkg::CFG_GAMMA, 32'd65535);
    send_item(make_item(bas_pkg::OP_RECORD, 4'd9, 24'hFFFFFF, 32'hFFFF_FFFF, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_RECORD, 4'd9, 24'hFFFFFF, 32'hFFFF_FFFF, 16'd0, 4'd0));
    set_reg(bas_pkg::CFG_GAMMA, 32'd0);
    set_reg(bas_pkg::CFG_BUCKET_LENGTH, 32'hFFFF_FFFF);
    send_item(make_item(bas_pkg::OP_RECORD, 4'd2, 24'd77, 32'hFFFF_FFFF, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'hFFFF, 4'd0));
    // arm count below one and above the table
    set_reg(bas_pkg::CFG_ARMS_IN_USE, 32'd0);
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'd0, 4'd13));
    set_reg(bas_pkg::CFG_ARMS_IN_USE, 32'd31);
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'd0, 4'd11));
    // epsilon clamps, widest bounds and crossed bounds
    set_reg(bas_pkg::CFG_EPSILON_MIN, 32'd0);
    set_reg(bas_pkg::CFG_EPSILON_MAX, 32'd65535);
    set_reg(bas_pkg::CFG_EPSILON_STEP, 32'd65535);
    send_item(make_item(bas_pkg::OP_RAISE, 4'd0, 24'd0, 32'd0, 16'd0, 4'd0));
    send_item(make_item(bas_pkg::OP_CHOOSE, 4'd0, 24'd0, 32'd0, 16'hFFFE, 4'd6));
    send_item(make_item(bas_pkg::OP_LOWER, 4'd0, 24'd0, 32'd0, 16'd0, 4'd0));
    set_reg(bas_pkg::CFG_EPSILON_MIN, 32'd50000);
    set_reg(bas_pkg::CFG_EPSILON_MAX, 32'd1000);
    send_item(make_item(bas_pkg::OP_RAISE, 4'd0, 24'd0, 32'd0, 16'd0, 4'd0));
    restore_defaults();
  endtask

  // New random settings between phases
  task automatic random_settings(input int phase);
    logic [31:0] bl;
    set_reg(bas_pkg::CFG_WINDOW_MODE, 32'($urandom_range(0, 3) != 0));
    case ($urandom_range(0, 3))
      0:       bl = $urandom_range(1, 50);
      1:       bl = $urandom | 32'h8000_0000;
      default: bl = $urandom_range(100, 100000);
    endcase
    if (phase == 5) bl = $urandom | 32'h8000_0000;
    set_reg(bas_pkg::CFG_BUCKET_LENGTH, bl);
    set_reg(bas_pkg::CFG_MIN_RUN_TIME,
            ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 20000));
    set_reg(bas_pkg::CFG_GAMMA, $urandom_range(0, 65535));
    set_reg(bas_pkg::CFG_ARMS_IN_USE, $urandom_range(0, 31));
    set_reg(bas_pkg::CFG_EPSILON_MIN, $urandom_range(0, 8000));
    set_reg(bas_pkg::CFG_EPSILON_MAX, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4000)
                                                                : $urandom_range(20000, 65535));
    set_reg(bas_pkg::CFG_EPSILON_STEP, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                                 : $urandom_range(0, 6000));
  endtask

  function automatic bas_pkg::item_t random_item;
    bas_pkg::item_t it;
    int             pick;
    longint         span;
    pick = $urandom_range(0, 99);
    it.operation   = (pick < 45) ? bas_pkg::OP_RECORD : (pick < 75) ? bas_pkg::OP_CHOOSE :
                     (pick < 87) ? bas_pkg::OP_RAISE : bas_pkg::OP_LOWER;
    it.arm         = 4'($urandom);
    it.coverage    = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 100)) : 24'($urandom);
    span           = longint'(sh_bucket_len) * 3;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    it.elapsed     = $urandom_range(0, 32'(span));
    it.random_draw = 16'($urandom);
    it.random_arm  = 4'($urandom);
    return it;
  endfunction

  task automatic test_random_traffic(input int phase, input int count);
    random_settings(phase);
    for (int k = 0; k < count; k++) send_item(random_item());
  endtask

  // Long receiver hold while items keep coming
  task automatic test_backpressure;
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++) send_item(random_item());
  endtask

  // Sender waits until every expected result is in
  task automatic test_sender_pause;
    for (int k = 0; k < 10; k++) send_item(random_item());
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    for (int k = 0; k < 10; k++) send_item(random_item());
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    result_stall = 1'b0;
    fails = 0;
    cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    tx_idle_pct = 16;
    rx_idle_pct = 63;
    sh_dynamic = bas_pkg::RST_WINDOW_MODE;
    sh_bucket_len = bas_pkg::RST_BUCKET_LENGTH;
    sh_min_run = bas_pkg::RST_MIN_RUN_TIME;
    sh_gamma = bas_pkg::RST_GAMMA;
    sh_arms = bas_pkg::RST_ARMS_IN_USE;
    sh_eps_min = bas_pkg::RST_EPSILON_MIN;
    sh_eps_max = bas_pkg::RST_EPSILON_MAX;
    sh_eps_step = bas_pkg::RST_EPSILON_STEP;
    eps_q = bas_pkg::RST_EPSILON;
    for (int i = 0; i < ARM_COUNT; i++) begin
      arm_win_cov[i] = '0;
      arm_win_time[i] = '0;
      arm_tot_cov[i] = '0;
      arm_tot_time[i] = '0;
      arm_fill[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    for (int p = 0; p < 8; p++) begin
      if (p == 3) begin
        tx_idle_pct = 63;
        rx_idle_pct = 16;
      end else if (p == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      test_random_traffic(p, 150);
      if (p == 1) test_backpressure();
      if (p == 4) test_sender_pause();
    end

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
